// ----- hdl/mcma_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the collection-matrix accumulator.
package mcma_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_BIAS    = 2;
  localparam int DEF_SYS_COMP    = 4;
  localparam int DEF_STATE_DEPTH = 1024;

  // Fixed field widths.
  localparam int CNT_W      = 16;
  localparam int PROB_W     = 18;
  localparam int PROBC_W    = 17;
  localparam int SUM_W      = 48;
  localparam int VISIT_W    = 32;
  localparam int ENERGY_W   = 32;
  localparam int SIDX_W     = 10;
  localparam int IDX_MAX_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 320;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PROBC_W-1:0] Q16_ONE = 17'h10000;

  typedef enum logic [1:0] {
    OP_MATRIX = 2'd0,
    OP_HIST   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_UNBIASED = 2'd2,
    ST_INDEX    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS = 3'd0,
    CFG_MIN0 = 3'd1,
    CFG_MAX0 = 3'd2,
    CFG_MIN1 = 3'd3,
    CFG_MAX1 = 3'd4,
    CFG_MAP0 = 3'd5,
    CFG_MAP1 = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } bk_state_t;

  // One input item as it arrives on the slave side.
  typedef struct packed {
    logic [1:0]              opcode;
    logic [CNT_W-1:0]        count_0;
    logic [CNT_W-1:0]        count_1;
    logic [CNT_W-1:0]        count_2;
    logic [CNT_W-1:0]        count_3;
    logic [1:0]              selected_component;
    logic signed [PROB_W-1:0] stay_probability;
    logic signed [PROB_W-1:0] removal_probability;
    logic signed [PROB_W-1:0] insertion_probability;
    logic signed [ENERGY_W-1:0] potential_energy;
    logic [SIDX_W-1:0]       state_index;
  } in_item_t;

  // A classified item waiting for the back end.
  typedef struct packed {
    op_t                       kind;
    status_t                   status;
    logic [IDX_MAX_W-1:0]      index;
    logic                      slot;
    logic [PROBC_W-1:0]        stay;
    logic [PROBC_W-1:0]        removal;
    logic [PROBC_W-1:0]        insertion;
    logic signed [ENERGY_W-1:0] energy;
  } qentry_t;

  // One result item.
  typedef struct packed {
    status_t                 status;
    logic [SUM_W-1:0]        stay_sum;
    logic [SUM_W-1:0]        removal_sum_0;
    logic [SUM_W-1:0]        insertion_sum_0;
    logic [SUM_W-1:0]        removal_sum_1;
    logic [SUM_W-1:0]        insertion_sum_1;
    logic [VISIT_W-1:0]      visit_count;
    logic signed [SUM_W-1:0] energy_sum;
  } result_t;

  // Clamp a signed Q2.16 probability to the range 0.0 .. 1.0.
  function automatic logic [PROBC_W-1:0] clamp_prob(input logic signed [PROB_W-1:0] raw);
    logic [PROBC_W-1:0] mag;
    mag = raw[PROBC_W-1:0];
    if (raw[PROB_W-1]) begin
      return '0;
    end else if (mag > Q16_ONE) begin
      return Q16_ONE;
    end
    return mag;
  endfunction

  // Unsigned 48-bit accumulate that sticks at all ones.
  function automatic logic [SUM_W-1:0] sat_add_prob(input logic [SUM_W-1:0] a,
                                                    input logic [PROBC_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // Count of the system component that a map value names.
  function automatic logic [CNT_W-1:0] pick_count(input logic [1:0] map, input in_item_t it);
    logic [CNT_W-1:0] c;
    unique case (map)
      2'd0:    c = it.count_0;
      2'd1:    c = it.count_1;
      2'd2:    c = it.count_2;
      default: c = it.count_3;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/macrostate_collection_matrix_accumulator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the transition-matrix collection-matrix and histogram accumulator.
//
// Usage: items arrive on the in_ stream; in_tuser carries the opcode (matrix update,
// histogram update, read entry) and in_tdata the particle counts, the moved
// component, three Q2.16 probabilities, the energy sample and the read index.
// Every item yields exactly one result transfer on the out_ stream; out_tuser holds
// the status and out_tdata the addressed entry after the update, or zeros on error or for OP_NONE.
// The user must write registers through the cfg_ port only while the block is idle; the block does not enforce it.
//
// An input transfer passes front stages 1 and 2, the queue, the memory read and the
// result register before out_tvalid rises. For each item the back end does a memory
// read, then modify and write back, and pops no other item in between; the front end
// classifies the next items meanwhile and a two-entry queue absorbs them.
//
// After reset the back end sweeps all STATE_DEPTH entries to zero, one per cycle,
// and in_tready stays low while it runs; configuration writes are taken during
// the sweep. When the receiver holds out_tready low, the result stays registered,
// the back end stops popping, and in_tready falls once queue and front pipeline
// are full.
module macrostate_collection_matrix_accumulator_unit import mcma_pkg::*; #(
  parameter int MAX_BIAS_COMPONENTS = DEF_MAX_BIAS,
  parameter int SYSTEM_COMPONENTS   = DEF_SYS_COMP,
  parameter int STATE_DEPTH         = DEF_STATE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // count_0, count_1, count_2, count_3, selected_component, stay_probability,
  // removal_probability, insertion_probability, potential_energy, state_index, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [1:0]             in_tuser,
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // stay_sum, removal_sum_0, insertion_sum_0, removal_sum_1, insertion_sum_1,
  // visit_count, energy_sum
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [1:0]             out_tuser
);

  in_item_t in_item;
  qentry_t  push_entry, q_head;
  logic     q_push, q_pop, q_empty, q_full, clear_busy;
  result_t  result;

  // Unpack the input transfer into its fields, lowest field first.
  assign in_item.opcode                = in_tuser;
  assign in_item.count_0               = in_tdata[15:0];
  assign in_item.count_1               = in_tdata[31:16];
  assign in_item.count_2               = in_tdata[47:32];
  assign in_item.count_3               = in_tdata[63:48];
  assign in_item.selected_component    = in_tdata[65:64];
  assign in_item.stay_probability      = in_tdata[83:66];
  assign in_item.removal_probability   = in_tdata[101:84];
  assign in_item.insertion_probability = in_tdata[119:102];
  assign in_item.potential_energy      = in_tdata[151:120];
  assign in_item.state_index           = in_tdata[161:152];

  mcma_front #(
    .MAX_BIAS_COMPONENTS (MAX_BIAS_COMPONENTS),
    .SYSTEM_COMPONENTS   (SYSTEM_COMPONENTS),
    .STATE_DEPTH         (STATE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  mcma_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  mcma_back #(
    .MAX_BIAS_COMPONENTS (MAX_BIAS_COMPONENTS),
    .STATE_DEPTH         (STATE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

  // Pack the result transfer, lowest field first.
  assign out_tuser = result.status;
  assign out_tdata = {result.energy_sum, result.visit_count,
                      result.insertion_sum_1, result.removal_sum_1,
                      result.insertion_sum_0, result.removal_sum_0,
                      result.stay_sum};

endmodule

// ----- hdl/mcma_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers, macrostate index forming and item classification.
module mcma_front import mcma_pkg::*; #(
  parameter int MAX_BIAS_COMPONENTS = DEF_MAX_BIAS,
  parameter int SYSTEM_COMPONENTS   = DEF_SYS_COMP,
  parameter int STATE_DEPTH         = DEF_STATE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  clear_busy,
  input  logic                  q_full,
  output logic                  q_push,
  output qentry_t               q_entry
);

  localparam int IDX_W = $clog2(STATE_DEPTH);

  // Configuration registers.
  logic [1:0]       bias_r;
  logic [CNT_W-1:0] min0_r, max0_r, min1_r, max1_r;
  logic [1:0]       map0_r, map1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= 2'd1;
      min0_r <= '0;
      max0_r <= '0;
      min1_r <= '0;
      max1_r <= '0;
      map0_r <= 2'd0;
      map1_r <= 2'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIAS: bias_r <= cfg_data[1:0];
        CFG_MIN0: min0_r <= cfg_data;
        CFG_MAX0: max0_r <= cfg_data;
        CFG_MIN1: min1_r <= cfg_data;
        CFG_MAX1: max1_r <= cfg_data;
        CFG_MAP0: map0_r <= cfg_data[1:0];
        CFG_MAP1: map1_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Stage 1 holds the raw item; stage 2 holds the range checks and the product.
  logic     s1_v_r;
  in_item_t s1_item_r;
  logic     s2_v_r;
  op_t      s2_kind_r;
  logic     s2_fail_r, s2_use1_r, s2_found_r, s2_slot_r;
  logic [CNT_W-1:0]          s2_d0_r;
  logic [2*CNT_W:0]          s2_prod_r;
  logic [PROBC_W-1:0]        s2_stay_r, s2_rem_r, s2_ins_r;
  logic signed [ENERGY_W-1:0] s2_energy_r;
  logic [SIDX_W-1:0]         s2_sidx_r;

  logic s2_free, s1_adv, in_acc;

  assign s2_free  = !s2_v_r || !q_full;
  assign s1_adv   = s1_v_r && s2_free;
  assign in_ready = !clear_busy && (!s1_v_r || s2_free);
  assign in_acc   = in_valid && in_ready;
  assign q_push   = s2_v_r && !q_full;

  // Stage 1 logic.
  logic [1:0]       nb;
  logic [CNT_W-1:0] c0, c1, d0, d1;
  logic [CNT_W:0]   span0;
  logic [2*CNT_W:0] prod;
  logic             use1, fail, match0, match1;

  always_comb begin
    if (bias_r == 2'd0) begin
      nb = 2'd1;
    end else if (32'(bias_r) > MAX_BIAS_COMPONENTS) begin
      nb = 2'(MAX_BIAS_COMPONENTS);
    end else begin
      nb = bias_r;
    end
  end

  assign use1   = (nb == 2'd2);
  assign c0     = (32'(map0_r) < SYSTEM_COMPONENTS) ? pick_count(map0_r, s1_item_r) : '0;
  assign c1     = (32'(map1_r) < SYSTEM_COMPONENTS) ? pick_count(map1_r, s1_item_r) : '0;
  assign fail   = (c0 < min0_r) || (c0 > max0_r) ||
                  (use1 && ((c1 < min1_r) || (c1 > max1_r)));
  assign d0     = c0 - min0_r;
  assign d1     = c1 - min1_r;
  assign span0  = (CNT_W+1)'(max0_r) - (CNT_W+1)'(min0_r) + (CNT_W+1)'(1);
  assign prod   = (2*CNT_W+1)'(d1) * (2*CNT_W+1)'(span0);
  // The first biased slot whose map names the moved component wins.
  assign match0 = (map0_r == s1_item_r.selected_component);
  assign match1 = use1 && (map1_r == s1_item_r.selected_component);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (q_push) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      s2_kind_r   <= op_t'(s1_item_r.opcode);
      s2_fail_r   <= fail;
      s2_use1_r   <= use1;
      s2_found_r  <= match0 || match1;
      s2_slot_r   <= !match0;
      s2_d0_r     <= d0;
      s2_prod_r   <= prod;
      s2_stay_r   <= clamp_prob(s1_item_r.stay_probability);
      s2_rem_r    <= clamp_prob(s1_item_r.removal_probability);
      s2_ins_r    <= clamp_prob(s1_item_r.insertion_probability);
      s2_energy_r <= s1_item_r.potential_energy;
      s2_sidx_r   <= s1_item_r.state_index;
    end
  end

  // Stage 2 logic: finish the index and pick the status.
  logic [2*CNT_W+1:0] idx;
  logic               idx_oob, sidx_oob;

  assign idx      = (2*CNT_W+2)'(s2_d0_r) + (s2_use1_r ? (2*CNT_W+2)'(s2_prod_r) : '0);
  assign idx_oob  = idx >= (2*CNT_W+2)'(STATE_DEPTH);
  assign sidx_oob = 32'(s2_sidx_r) >= STATE_DEPTH;

  always_comb begin
    q_entry           = '0;
    q_entry.kind      = s2_kind_r;
    q_entry.slot      = s2_slot_r;
    q_entry.stay      = s2_stay_r;
    q_entry.removal   = s2_rem_r;
    q_entry.insertion = s2_ins_r;
    q_entry.energy    = s2_energy_r;
    q_entry.index     = IDX_MAX_W'(idx[IDX_W-1:0]);
    q_entry.status    = ST_OK;
    unique case (s2_kind_r)
      OP_MATRIX: begin
        if (s2_fail_r) begin
          q_entry.status = ST_RANGE;
        end else if (idx_oob) begin
          q_entry.status = ST_INDEX;
        end else if (!s2_found_r) begin
          q_entry.status = ST_UNBIASED;
        end
      end
      OP_HIST: begin
        if (s2_fail_r) begin
          q_entry.status = ST_RANGE;
        end else if (idx_oob) begin
          q_entry.status = ST_INDEX;
        end
      end
      OP_READ: begin
        q_entry.index = IDX_MAX_W'(s2_sidx_r);
        if (sidx_oob) begin
          q_entry.status = ST_INDEX;
        end
      end
      OP_NONE: ;
    endcase
  end

endmodule

// ----- hdl/mcma_queue.sv -----
`timescale 1ns / 1ps
// Short first-in first-out queue of classified items between front and back.
module mcma_queue import mcma_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_entry,
  input  logic    pop,
  output qentry_t head,
  output logic    empty,
  output logic    full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

  qentry_t            slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W_Q-1:0] fill_r;

  assign empty = (fill_r == '0);
  assign full  = (fill_r == CNT_W_Q'(QUEUE_DEPTH));
  assign head  = slots_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        fill_r <= fill_r + CNT_W_Q'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - CNT_W_Q'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- hdl/mcma_back.sv -----
`timescale 1ns / 1ps
// Back end: state memories, read-modify-write sequencer, clearing pass and result register.
module mcma_back import mcma_pkg::*; #(
  parameter int MAX_BIAS_COMPONENTS = DEF_MAX_BIAS,
  parameter int STATE_DEPTH         = DEF_STATE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  qentry_t q_head,
  input  logic    q_empty,
  output logic    q_pop,
  output logic    clear_busy,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  localparam int IDX_W = $clog2(STATE_DEPTH);
  localparam int NB    = MAX_BIAS_COMPONENTS;

  typedef logic [NB-1:0][SUM_W-1:0] row_t;

  bk_state_t  state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r;
  qentry_t    work_r;
  logic       out_valid_r;
  result_t    res_r, res_nxt;

  // State memories; the removal and insertion sums keep one row per state for all slots.
  logic [SUM_W-1:0]        stay_mem  [STATE_DEPTH];
  row_t                    rem_mem   [STATE_DEPTH];
  row_t                    ins_mem   [STATE_DEPTH];
  logic [VISIT_W-1:0]      visit_mem [STATE_DEPTH];
  logic signed [SUM_W-1:0] en_mem    [STATE_DEPTH];

  logic [SUM_W-1:0]        stay_rd_r;
  row_t                    rem_rd_r, ins_rd_r;
  logic [VISIT_W-1:0]      visit_rd_r;
  logic signed [SUM_W-1:0] en_rd_r;

  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic we_mat, we_hist;
  logic ok, is_mat, is_hist, show;

  logic [SUM_W-1:0]        stay_new, stay_post;
  row_t                    rem_new, ins_new, rem_post, ins_post;
  logic [VISIT_W-1:0]      visit_new, visit_post;
  logic signed [SUM_W-1:0] en_new, en_post;
  logic signed [SUM_W:0]   en_wide;
  logic [SUM_W-1:0]        rem1_post, ins1_post;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: begin
        if (clr_cnt_r == IDX_W'(STATE_DEPTH - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_pop) begin
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: state_nxt = BK_IDLE;
      default:   state_nxt = BK_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop      = 1'b0;
    clear_busy = 1'b0;
    we_mat     = 1'b0;
    we_hist    = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        clear_busy = 1'b1;
        we_mat     = 1'b1;
        we_hist    = 1'b1;
      end
      BK_IDLE: begin
        q_pop = !q_empty && (!out_valid_r || out_ready);
      end
      BK_UPDATE: begin
        we_mat  = is_mat;
        we_hist = is_hist;
      end
      default: clear_busy = 1'b1;
    endcase
  end

  assign rd_addr = q_head.index[IDX_W-1:0];
  assign wr_addr = (state_r == BK_CLEAR) ? clr_cnt_r : work_r.index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (state_r == BK_UPDATE) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_r <= q_head;
    end
    if (state_r == BK_UPDATE) begin
      res_r <= res_nxt;
    end
  end

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (we_mat) begin
      stay_mem[wr_addr] <= (state_r == BK_CLEAR) ? '0 : stay_new;
      rem_mem[wr_addr]  <= (state_r == BK_CLEAR) ? '0 : rem_new;
      ins_mem[wr_addr]  <= (state_r == BK_CLEAR) ? '0 : ins_new;
    end
    if (q_pop) begin
      stay_rd_r <= stay_mem[rd_addr];
      rem_rd_r  <= rem_mem[rd_addr];
      ins_rd_r  <= ins_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (we_hist) begin
      visit_mem[wr_addr] <= (state_r == BK_CLEAR) ? '0 : visit_new;
      en_mem[wr_addr]    <= (state_r == BK_CLEAR) ? '0 : en_new;
    end
    if (q_pop) begin
      visit_rd_r <= visit_mem[rd_addr];
      en_rd_r    <= en_mem[rd_addr];
    end
  end

  // Update arithmetic.
  assign ok      = (work_r.status == ST_OK);
  assign is_mat  = ok && (work_r.kind == OP_MATRIX);
  assign is_hist = ok && (work_r.kind == OP_HIST);
  assign show    = ok && (work_r.kind != OP_NONE);

  assign stay_new = sat_add_prob(stay_rd_r, work_r.stay);

  always_comb begin
    for (int k = 0; k < NB; k++) begin
      if (k == int'(work_r.slot)) begin
        rem_new[k] = sat_add_prob(rem_rd_r[k], work_r.removal);
        ins_new[k] = sat_add_prob(ins_rd_r[k], work_r.insertion);
      end else begin
        rem_new[k] = rem_rd_r[k];
        ins_new[k] = ins_rd_r[k];
      end
    end
  end

  assign visit_new = (visit_rd_r == '1) ? visit_rd_r : visit_rd_r + VISIT_W'(1);

  // Signed energy sum clamped to the 48-bit range.
  assign en_wide = (SUM_W+1)'(en_rd_r) + (SUM_W+1)'(work_r.energy);
  always_comb begin
    if (en_wide[SUM_W] != en_wide[SUM_W-1]) begin
      en_new = en_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      en_new = en_wide[SUM_W-1:0];
    end
  end

  assign stay_post  = is_mat  ? stay_new  : stay_rd_r;
  assign rem_post   = is_mat  ? rem_new   : rem_rd_r;
  assign ins_post   = is_mat  ? ins_new   : ins_rd_r;
  assign visit_post = is_hist ? visit_new : visit_rd_r;
  assign en_post    = is_hist ? en_new    : en_rd_r;

  generate
    if (NB > 1) begin : g_two_slots
      assign rem1_post = rem_post[NB-1];
      assign ins1_post = ins_post[NB-1];
    end else begin : g_one_slot
      assign rem1_post = '0;
      assign ins1_post = '0;
    end
  endgenerate

  always_comb begin
    res_nxt        = '0;
    res_nxt.status = work_r.status;
    if (show) begin
      res_nxt.stay_sum        = stay_post;
      res_nxt.removal_sum_0   = rem_post[0];
      res_nxt.insertion_sum_0 = ins_post[0];
      res_nxt.removal_sum_1   = rem1_post;
      res_nxt.insertion_sum_1 = ins1_post;
      res_nxt.visit_count     = visit_post;
      res_nxt.energy_sum      = en_post;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = res_r;

endmodule
